@@ rtl/topological_sort_engine_top_assert.svh @@
// Assertion macros for the topological sort engine.
// Each macro samples on the rising edge of clk and is quiet while rst is high.
`ifndef TOPOLOGICAL_SORT_ENGINE_TOP_ASSERT_SVH
`define TOPOLOGICAL_SORT_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication
`define TSE_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define TSE_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/tse_pkg.sv @@
package tse_pkg;

  // Default sizes of the graph stores
  localparam int TSE_MAX_VERTICES = 64;
  localparam int TSE_MAX_EDGES    = 256;

  // Input word kinds
  localparam logic KIND_EDGE   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_ORDERED  = 2'd0;
  localparam logic [1:0] ST_CYCLE    = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept_edge;
    logic insert;
    logic seed_start;
    logic seed_step;
    logic pop;
    logic head_rd;
    logic head_ld;
    logic edge_rd;
    logic deg_rd;
    logic deg_wr;
    logic emit_start;
    logic emit_rd;
    logic emit_ld;
    logic load_err;
    logic clear;
  } tse_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic edge_ok;
    logic ovf;
    logic seed_done;
    logic queue_more;
    logic edge_more;
    logic all_queued;
    logic out_free;
    logic emit_last;
  } tse_stat_t;

endpackage

@@ rtl/tse_ctrl.sv @@
module tse_ctrl
  import tse_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  input  logic      kind,
  output logic      item_stall,
  input  tse_stat_t stat,
  output tse_cmd_t  cmd
);

  typedef enum logic [13:0] {
    S_IDLE    = 14'h0001,
    S_INS     = 14'h0002,
    S_SEED    = 14'h0004,
    S_POP     = 14'h0008,
    S_HEAD_RD = 14'h0010,
    S_HEAD_LD = 14'h0020,
    S_EDGE_RD = 14'h0040,
    S_DEG_RD  = 14'h0080,
    S_DEG_WR  = 14'h0100,
    S_CHECK   = 14'h0200,
    S_EMIT_RD = 14'h0400,
    S_EMIT_LD = 14'h0800,
    S_ERR     = 14'h1000,
    S_CLEAR   = 14'h2000
  } state_t;

  state_t state;
  state_t state_next;

  // Take a new word only when idle
  assign item_stall = (state != S_IDLE);

  // Advance the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decode the next state and the datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          if (kind == KIND_EDGE) begin
            cmd.accept_edge = 1'b1;
            if (stat.edge_ok) begin
              state_next = S_INS;
            end
          end else if (stat.ovf) begin
            state_next = S_ERR;
          end else begin
            cmd.seed_start = 1'b1;
            state_next     = S_SEED;
          end
        end
      end
      S_INS: begin
        cmd.insert = 1'b1;
        state_next = S_IDLE;
      end
      S_SEED: begin
        if (stat.seed_done) begin
          state_next = S_POP;
        end else begin
          cmd.seed_step = 1'b1;
        end
      end
      S_POP: begin
        if (stat.queue_more) begin
          cmd.pop    = 1'b1;
          state_next = S_HEAD_RD;
        end else begin
          state_next = S_CHECK;
        end
      end
      S_HEAD_RD: begin
        cmd.head_rd = 1'b1;
        state_next  = S_HEAD_LD;
      end
      S_HEAD_LD: begin
        cmd.head_ld = 1'b1;
        state_next  = S_EDGE_RD;
      end
      S_EDGE_RD: begin
        if (stat.edge_more) begin
          cmd.edge_rd = 1'b1;
          state_next  = S_DEG_RD;
        end else begin
          state_next = S_POP;
        end
      end
      S_DEG_RD: begin
        cmd.deg_rd = 1'b1;
        state_next = S_DEG_WR;
      end
      S_DEG_WR: begin
        cmd.deg_wr = 1'b1;
        state_next = S_EDGE_RD;
      end
      S_CHECK: begin
        if (stat.all_queued) begin
          cmd.emit_start = 1'b1;
          state_next     = S_EMIT_RD;
        end else begin
          state_next = S_ERR;
        end
      end
      S_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_next  = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (stat.out_free) begin
          cmd.emit_ld = 1'b1;
          state_next  = stat.emit_last ? S_CLEAR : S_EMIT_RD;
        end
      end
      S_ERR: begin
        if (stat.out_free) begin
          cmd.load_err = 1'b1;
          state_next   = S_CLEAR;
        end
      end
      S_CLEAR: begin
        cmd.clear  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/tse_datapath.sv @@
module tse_datapath
  import tse_pkg::*;
#(
  parameter int MAX_VERTICES = TSE_MAX_VERTICES,
  parameter int MAX_EDGES    = TSE_MAX_EDGES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [6:0] cfg_data,
  input  logic [6:0] from_vertex,
  input  logic [6:0] to_vertex,
  input  logic       result_stall,
  output logic       result_valid,
  output logic [6:0] vertex,
  output logic       last,
  output logic [1:0] status,
  input  tse_cmd_t   cmd,
  output tse_stat_t  stat
);

  localparam int VIW = $clog2(MAX_VERTICES);
  localparam int CW  = $clog2(MAX_VERTICES + 1);
  localparam int EW  = $clog2(MAX_EDGES);
  localparam int EPW = EW + 1;
  localparam logic [EPW-1:0] NULL_LINK = EPW'(MAX_EDGES);
  localparam logic [CW-1:0]  MAX_V     = CW'(MAX_VERTICES);

  // Memories
  logic [VIW-1:0] edge_target [MAX_EDGES];
  logic [EPW-1:0] edge_link   [MAX_EDGES];
  logic [EW-1:0]  head_mem    [MAX_VERTICES];
  logic [EPW-1:0] deg_mem     [MAX_VERTICES];
  logic [VIW-1:0] order_queue [MAX_VERTICES];

  // Per-entry valid bits for the stores that reset to a known value
  logic [MAX_VERTICES-1:0] head_valid;
  logic [MAX_VERTICES-1:0] deg_valid;

  // Registered read data
  logic [VIW-1:0] et_q;
  logic [EPW-1:0] el_q;
  logic [EW-1:0]  hd_q;
  logic           hv_q;
  logic [EPW-1:0] dd_q;
  logic           dv_q;
  logic [VIW-1:0] qd_q;

  // Control and working registers
  logic [CW-1:0]  n;
  logic [EPW-1:0] total;
  logic           overflow_seen;
  logic [CW-1:0]  queue_front;
  logic [CW-1:0]  queue_back;
  logic [CW-1:0]  scan;
  logic           pend;
  logic [VIW-1:0] pend_idx;
  logic [CW-1:0]  idx;
  logic [EPW-1:0] link;
  logic [VIW-1:0] a_idx;
  logic [VIW-1:0] b_idx;
  logic [VIW-1:0] t_idx;

  logic [VIW-1:0] from_idx;
  logic [VIW-1:0] to_idx;
  logic [EPW-1:0] deg_cur;
  logic           push_en;
  logic [VIW-1:0] push_val;
  logic           scan_more;

  assign from_idx  = VIW'(from_vertex - 7'd1);
  assign to_idx    = VIW'(to_vertex - 7'd1);
  assign deg_cur   = dv_q ? dd_q : '0;
  assign scan_more = (scan < n);

  // Pick the vertex to queue, from the seeding scan or from a drained target
  always_comb begin
    push_en  = 1'b0;
    push_val = pend_idx;
    if (cmd.seed_step && pend && (deg_cur == '0)) begin
      push_en = 1'b1;
    end else if (cmd.deg_wr && (deg_cur == EPW'(1))) begin
      push_en  = 1'b1;
      push_val = t_idx;
    end
  end

  // Status towards the controller
  always_comb begin
    stat            = '0;
    stat.edge_ok    = (from_vertex != 7'd0) && (from_vertex <= 7'(n)) &&
                      (to_vertex != 7'd0) && (to_vertex <= 7'(n)) &&
                      (total < NULL_LINK);
    stat.ovf        = overflow_seen;
    stat.seed_done  = !scan_more && !pend;
    stat.queue_more = (queue_front < queue_back);
    stat.edge_more  = (link < total);
    stat.all_queued = (queue_back == n);
    stat.out_free   = !result_valid || !result_stall;
    stat.emit_last  = ((idx + CW'(1)) == n);
  end

  // Vertex count register, clamped to the supported range
  always_ff @(posedge clk) begin
    if (rst) begin
      n <= CW'(1);
    end else if (cfg_we) begin
      if (cfg_data == 7'd0) begin
        n <= CW'(1);
      end else if (cfg_data > 7'(MAX_VERTICES)) begin
        n <= MAX_V;
      end else begin
        n <= CW'(cfg_data);
      end
    end
  end

  // Edge count, overflow flag, queue pointers and valid bits
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      total         <= '0;
      overflow_seen <= 1'b0;
      queue_front   <= '0;
      queue_back    <= '0;
      head_valid    <= '0;
      deg_valid     <= '0;
    end else begin
      if (cmd.accept_edge && !stat.edge_ok) begin
        overflow_seen <= 1'b1;
      end
      if (cmd.insert) begin
        total             <= total + EPW'(1);
        head_valid[a_idx] <= 1'b1;
        deg_valid[b_idx]  <= 1'b1;
      end
      if (cmd.deg_wr && (deg_cur != '0)) begin
        deg_valid[t_idx] <= 1'b1;
      end
      if (cmd.seed_start) begin
        queue_front <= '0;
        queue_back  <= '0;
      end else begin
        if (cmd.pop) begin
          queue_front <= queue_front + CW'(1);
        end
        if (push_en && (queue_back < MAX_V)) begin
          queue_back <= queue_back + CW'(1);
        end
      end
    end
  end

  // Working registers of the sort
  always_ff @(posedge clk) begin
    if (cmd.accept_edge) begin
      a_idx <= from_idx;
      b_idx <= to_idx;
    end
    if (cmd.seed_start) begin
      scan <= '0;
      pend <= 1'b0;
    end else if (cmd.seed_step) begin
      pend <= scan_more;
      if (scan_more) begin
        pend_idx <= scan[VIW-1:0];
        scan     <= scan + CW'(1);
      end
    end
    if (cmd.head_ld) begin
      link <= hv_q ? EPW'(hd_q) : NULL_LINK;
    end else if (cmd.deg_rd) begin
      link  <= el_q;
    end
    if (cmd.deg_rd) begin
      t_idx <= et_q;
    end
    if (cmd.emit_start) begin
      idx <= '0;
    end else if (cmd.emit_ld) begin
      idx <= idx + CW'(1);
    end
  end

  // Edge store: write on insert, read along a vertex's list
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      edge_target[total[EW-1:0]] <= b_idx;
      edge_link[total[EW-1:0]]   <= hv_q ? EPW'(hd_q) : NULL_LINK;
    end
    if (cmd.edge_rd) begin
      et_q <= edge_target[link[EW-1:0]];
      el_q <= edge_link[link[EW-1:0]];
    end
  end

  // List heads
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      head_mem[a_idx] <= total[EW-1:0];
    end
    if (cmd.accept_edge) begin
      hd_q <= head_mem[from_idx];
      hv_q <= head_valid[from_idx];
    end else if (cmd.head_rd) begin
      hd_q <= head_mem[qd_q];
      hv_q <= head_valid[qd_q];
    end
  end

  // In-degrees: raise on insert, lower while draining
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      deg_mem[b_idx] <= deg_cur + EPW'(1);
    end else if (cmd.deg_wr && (deg_cur != '0)) begin
      deg_mem[t_idx] <= deg_cur - EPW'(1);
    end
    if (cmd.accept_edge) begin
      dd_q <= deg_mem[to_idx];
      dv_q <= deg_valid[to_idx];
    end else if (cmd.seed_step && scan_more) begin
      dd_q <= deg_mem[scan[VIW-1:0]];
      dv_q <= deg_valid[scan[VIW-1:0]];
    end else if (cmd.deg_rd) begin
      dd_q <= deg_mem[et_q];
      dv_q <= deg_valid[et_q];
    end
  end

  // Order queue
  always_ff @(posedge clk) begin
    if (push_en && (queue_back < MAX_V)) begin
      order_queue[queue_back[VIW-1:0]] <= push_val;
    end
    if (cmd.pop) begin
      qd_q <= order_queue[queue_front[VIW-1:0]];
    end else if (cmd.emit_rd) begin
      qd_q <= order_queue[idx[VIW-1:0]];
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit_ld || cmd.load_err) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_ld) begin
      vertex <= 7'(qd_q) + 7'd1;
      last   <= stat.emit_last;
      status <= ST_ORDERED;
    end else if (cmd.load_err) begin
      vertex <= 7'd0;
      last   <= 1'b1;
      status <= overflow_seen ? ST_OVERFLOW : ST_CYCLE;
    end
  end

endmodule

@@ rtl/topological_sort_engine_top.sv @@
// Topological sort engine (Kahn's method).
// Input channel item_valid/item_stall carries words of kind, from_vertex and
// to_vertex. An edge word (kind 0) reads the list head and target in-degree
// in the accept cycle and writes them back in the next; a dropped edge skips
// the write-back.
// A finish word (kind 1) sorts the loaded graph and gives its results on
// result_valid/result_stall: the n vertices in order with last on the final
// one, or a single word with vertex 0 and status 1 (cycle) or 2 (dropped edge).
// A stalled result holds its word; the emission pauses until the output
// register frees.
// The config channel cfg_valid/cfg_ready writes the vertex count (0 acts as 1,
// above the vertex limit acts as the limit); write it only while idle.
// Synchronous reset clears the vertex count to 1 and empties the graph at once;
// the graph also empties after every finish.
`include "topological_sort_engine_top_assert.svh"

module topological_sort_engine_top
  import tse_pkg::*;
#(
  parameter int MAX_VERTICES = TSE_MAX_VERTICES,
  parameter int MAX_EDGES    = TSE_MAX_EDGES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic       kind,
  input  logic [6:0] from_vertex,
  input  logic [6:0] to_vertex,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [6:0] vertex,
  output logic       last,
  output logic [1:0] status
);

  tse_cmd_t   cmd;
  tse_stat_t  stat;
  logic       result_load;
  logic [6:0] write_cmds;

  // Config writes are always taken
  assign cfg_ready = 1'b1;

  tse_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .kind       (kind),
    .item_stall (item_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  tse_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .from_vertex  (from_vertex),
    .to_vertex    (to_vertex),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .vertex       (vertex),
    .last         (last),
    .status       (status),
    .cmd          (cmd),
    .stat         (stat)
  );

  // Group the commands that change stored state
  assign result_load = cmd.emit_ld || cmd.load_err;
  assign write_cmds  = {cmd.insert, cmd.pop, cmd.deg_wr, cmd.emit_ld, cmd.load_err,
                        cmd.clear, cmd.seed_start};

  `TSE_CHECK(a_one_write_cmd, 1'b1, $onehot0(write_cmds), "more than one store command")
  `TSE_CHECK(a_load_when_free, result_load, !(result_valid && result_stall), "result overwritten")
  `TSE_CHECK_NEXT(a_clear_drops_ovf, cmd.clear, !stat.ovf, "overflow survives clear")

endmodule

@@ test/topological_sort_checker.sv @@
`timescale 1ns / 1ps

module topological_sort_checker
  import tse_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [6:0] cfg_data,
  input  logic       item_valid,
  input  logic       item_stall,
  input  logic       kind,
  input  logic [6:0] from_vertex,
  input  logic [6:0] to_vertex,
  input  logic       result_valid,
  input  logic       result_stall,
  input  logic [6:0] vertex,
  input  logic       last,
  input  logic [1:0] status,
  output int         fail_count,
  output int         pending
);

  localparam int NV = TSE_MAX_VERTICES;
  localparam int NE = TSE_MAX_EDGES;
  localparam int EW = $clog2(NE + 1);

  typedef struct packed {
    logic [6:0] vertex;
    logic       last;
    logic [1:0] status;
  } order_word_t;

  // Shadow copy of the graph stores
  logic [6:0]    vertex_limit;
  logic [6:0]    arc_target [NE];
  logic [EW-1:0] arc_next [NE];
  logic [EW-1:0] list_head [1:NV];
  logic [EW-1:0] in_deg [1:NV];
  logic [EW-1:0] arc_total;
  logic          dropped;
  order_word_t   expected_order [$];
  int            errors = 0;

  // Count in effect: zero acts as one, anything above the limit as the limit
  function automatic int live_vertices();
    if (vertex_limit == 0) return 1;
    if (vertex_limit > NV) return NV;
    return int'(vertex_limit);
  endfunction

  function automatic void clear_graph();
    for (int v = 1; v <= NV; v++) begin
      list_head[v] = EW'(NE);
      in_deg[v]    = '0;
    end
    arc_total = '0;
    dropped   = 1'b0;
  endfunction

  // Prepend the arc to its source list; drop it on a bad endpoint or a full store
  function automatic void add_arc(logic [6:0] src, logic [6:0] dst);
    int n;
    n = live_vertices();
    if (src == 0 || src > n || dst == 0 || dst > n || arc_total >= NE) begin
      dropped = 1'b1;
    end else begin
      arc_target[arc_total] = dst;
      arc_next[arc_total]   = list_head[src];
      list_head[src]        = arc_total;
      arc_total             = arc_total + 1'b1;
      in_deg[dst]           = in_deg[dst] + 1'b1;
    end
  endfunction

  // Kahn's method over the loaded graph, then empty the stores
  function automatic void order_graph();
    int            n;
    int            front;
    int            back;
    logic [EW-1:0] e;
    logic [6:0]    v;
    logic [6:0]    t;
    logic [6:0]    order_q [NV];
    order_word_t   word;
    n     = live_vertices();
    front = 0;
    back  = 0;
    if (dropped) begin
      word.vertex = 7'd0;
      word.last   = 1'b1;
      word.status = ST_OVERFLOW;
      expected_order.push_back(word);
    end else begin
      // seed with every source vertex, lowest first
      for (int i = 1; i <= n; i++) begin
        if (in_deg[i] == 0) begin
          order_q[back] = 7'(i);
          back++;
        end
      end
      // pop and release targets, newest arc first
      while (front < back) begin
        v = order_q[front];
        front++;
        e = list_head[v];
        while (e < arc_total) begin
          t = arc_target[e];
          if (in_deg[t] != 0) begin
            in_deg[t] = in_deg[t] - 1'b1;
            if (in_deg[t] == 0 && back < NV) begin
              order_q[back] = t;
              back++;
            end
          end
          e = arc_next[e];
        end
      end
      if (back == n) begin
        for (int i = 0; i < n; i++) begin
          word.vertex = order_q[i];
          word.last   = (i == n - 1);
          word.status = ST_ORDERED;
          expected_order.push_back(word);
        end
      end else begin
        word.vertex = 7'd0;
        word.last   = 1'b1;
        word.status = ST_CYCLE;
        expected_order.push_back(word);
      end
    end
    clear_graph();
  endfunction

  // Compare one result word with the oldest expectation
  function automatic void check_word();
    order_word_t want;
    if (expected_order.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: unexpected result word: vertex %0d last %0d status %0d",
                 $time, vertex, last, status);
    end else begin
      want = expected_order.pop_front();
      if (vertex !== want.vertex || last !== want.last || status !== want.status) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result mismatch: expected vertex %0d last %0d status %0d, %s%0d %0d %0d",
                   $time, want.vertex, want.last, want.status,
                   "got vertex/last/status ", vertex, last, status);
      end
    end
  endfunction

  // Track config, input and result words at each edge
  always @(posedge clk) begin
    if (rst) begin
      vertex_limit = 7'd1;
      clear_graph();
      expected_order.delete();
    end else begin
      if (cfg_valid && cfg_ready) vertex_limit = cfg_data;
      if (item_valid && !item_stall) begin
        if (kind == KIND_EDGE) add_arc(from_vertex, to_vertex);
        else order_graph();
      end
      if (result_valid && !result_stall) check_word();
    end
    pending    <= expected_order.size();
    fail_count <= errors;
  end

endmodule

@@ test/tb_topological_sort_engine_top.sv @@
`timescale 1ns / 1ps

module tb_topological_sort_engine_top;
  import tse_pkg::*;

  localparam int NV = TSE_MAX_VERTICES;
  localparam int NE = TSE_MAX_EDGES;

  typedef enum int {
    GRAPH_DAG,
    GRAPH_LOOP,
    GRAPH_BAD_END,
    GRAPH_NOISE
  } graph_shape_t;

  typedef struct {
    logic [6:0] src;
    logic [6:0] dst;
  } arc_t;

  logic       clk;
  logic       rst          = 1'b1;
  logic       cfg_valid    = 1'b0;
  logic       cfg_ready;
  logic [6:0] cfg_data     = '0;
  logic       item_valid   = 1'b0;
  logic       item_stall;
  logic       kind         = KIND_EDGE;
  logic [6:0] from_vertex  = '0;
  logic [6:0] to_vertex    = '0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic [6:0] vertex;
  logic       last;
  logic [1:0] status;
  int         fail_count;
  int         pending;
  bit         quiet        = 1'b0;
  int         vertex_span  = 1;
  int         items_sent   = 0;

  topological_sort_engine_top u_dut (.*);

  topological_sort_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hold off result words now and then
  always @(posedge clk) result_stall <= !quiet && ($urandom_range(0, 99) < 6);

  // Present one input word and hold it until taken
  task automatic send_word(logic k, logic [6:0] src, logic [6:0] dst);
    while (!quiet && $urandom_range(0, 99) < 6) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid  <= 1'b1;
    kind        <= k;
    from_vertex <= src;
    to_vertex   <= dst;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_finish();
    send_word(KIND_FINISH, 7'($urandom), 7'($urandom));
  endtask

  // Wait for every expected word, then let the block finish clearing
  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_count(logic [6:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid   <= 1'b0;
    vertex_span = (value == 0) ? 1 : (value > NV) ? NV : int'(value);
  endtask

  // Load a graph over a hidden random ranking, add its flaw if its shape has one, then sort
  task automatic load_and_sort(graph_shape_t shape, int arcs);
    int         n;
    int         i;
    int         j;
    int         tmp;
    logic [6:0] rank [NV];
    arc_t       plan [$];
    arc_t       odd;
    n = vertex_span;
    for (i = 0; i < n; i++) rank[i] = 7'(i + 1);
    for (i = n - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      tmp     = int'(rank[i]);
      rank[i] = rank[j];
      rank[j] = 7'(tmp);
    end
    for (int k = 0; k < arcs; k++) begin
      if (n < 2 || (shape == GRAPH_NOISE && $urandom_range(0, 1) == 1)) begin
        odd.src = 7'($urandom);
        odd.dst = 7'($urandom);
      end else begin
        // forward along the ranking keeps the graph acyclic
        i       = $urandom_range(0, n - 2);
        j       = $urandom_range(i + 1, n - 1);
        odd.src = rank[i];
        odd.dst = rank[j];
      end
      plan.push_back(odd);
    end
    if (shape == GRAPH_LOOP) begin
      if (n < 2) begin
        odd.src = 7'd1;
        odd.dst = 7'd1;
      end else if ($urandom_range(0, 3) == 0) begin
        odd.src = rank[$urandom_range(0, n - 1)];
        odd.dst = odd.src;
      end else begin
        // forward arc plus its reverse closes a ring
        i       = $urandom_range(0, n - 2);
        j       = $urandom_range(i + 1, n - 1);
        odd.src = rank[i];
        odd.dst = rank[j];
        plan.push_back(odd);
        odd.src = rank[j];
        odd.dst = rank[i];
      end
      plan.insert($urandom_range(0, plan.size()), odd);
    end else if (shape == GRAPH_BAD_END) begin
      odd.src = rank[$urandom_range(0, n - 1)];
      odd.dst = rank[$urandom_range(0, n - 1)];
      tmp     = ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(n + 1, 127);
      if ($urandom_range(0, 1) == 1) odd.src = 7'(tmp);
      else odd.dst = 7'(tmp);
      plan.insert($urandom_range(0, plan.size()), odd);
    end
    foreach (plan[k]) send_word(KIND_EDGE, plan[k].src, plan[k].dst);
    send_finish();
  endtask

  initial begin
    int           pick;
    int           arcs;
    int           phase;
    graph_shape_t shape;
    logic [6:0]   count_value;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // lone vertex straight after reset
    send_word(KIND_FINISH, 7'h7F, 7'h7F);

    // count of zero acts as one; a self loop is a cycle
    settle();
    write_count(7'd0);
    send_word(KIND_EDGE, 7'd1, 7'd1);
    send_word(KIND_FINISH, 7'd0, 7'd0);

    // four vertices with shared targets
    settle();
    write_count(7'd4);
    send_word(KIND_EDGE, 7'd1, 7'd2);
    send_word(KIND_EDGE, 7'd1, 7'd3);
    send_word(KIND_EDGE, 7'd2, 7'd3);
    send_word(KIND_EDGE, 7'd4, 7'd1);
    send_word(KIND_EDGE, 7'd4, 7'd2);
    send_finish();

    // three-vertex ring, loaded while the previous order drains
    send_word(KIND_EDGE, 7'd1, 7'd2);
    send_word(KIND_EDGE, 7'd2, 7'd3);
    send_word(KIND_EDGE, 7'd3, 7'd1);
    send_finish();

    // endpoint zero, endpoint above the count, top bits set
    send_word(KIND_EDGE, 7'd0, 7'd1);
    send_word(KIND_EDGE, 7'd2, 7'd3);
    send_finish();
    send_word(KIND_EDGE, 7'd1, 7'd5);
    send_finish();
    send_word(KIND_EDGE, 7'h7F, 7'h40);
    send_finish();

    // count above the limit acts as the limit
    settle();
    write_count(7'd127);
    send_word(KIND_EDGE, 7'd64, 7'd1);
    send_word(KIND_EDGE, 7'd2, 7'd64);
    send_finish();
    settle();
    write_count(7'd64);
    send_finish();

    // fill the edge store; one edge more is dropped
    load_and_sort(GRAPH_DAG, NE + 1);

    // random graphs; keep the count for some so loading overlaps the result stream
    phase = 0;
    while (items_sent < 400) begin
      if (phase == 0 || $urandom_range(0, 99) < 60) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) count_value = 7'd0;
        else if (pick < 8) count_value = 7'($urandom_range(NV + 1, 127));
        else if (pick < 14) count_value = 7'(NV);
        else if (pick < 20) count_value = 7'd1;
        else count_value = 7'($urandom_range(2, 12));
        settle();
        write_count(count_value);
      end
      quiet <= (phase >= 3 && phase < 9);
      pick = $urandom_range(0, 99);
      if (pick < 65) shape = GRAPH_DAG;
      else if (pick < 78) shape = GRAPH_LOOP;
      else if (pick < 90) shape = GRAPH_BAD_END;
      else shape = GRAPH_NOISE;
      if (vertex_span < 2) arcs = 0;
      else arcs = $urandom_range(0, (vertex_span > 8) ? 24 : 3 * vertex_span);
      load_and_sort(shape, arcs);
      phase++;
    end

    settle();
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_topological_sort_engine_top: done, clean");
    end else begin
      $display("tb_topological_sort_engine_top: done, errors");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #10_000_000;
    $display("tb_topological_sort_engine_top: done, errors");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/tse_pkg.sv
rtl/tse_ctrl.sv
rtl/tse_datapath.sv
rtl/topological_sort_engine_top.sv
test/topological_sort_checker.sv
test/tb_topological_sort_engine_top.sv
